// ===== rtl/core/aph_pkg.sv =====
// ----------------------------------------------------------------------------
// aph_pkg
// Shared types, codes, widths and the bin edge cosine function of the
// angular pair histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none

package aph_pkg;

	localparam int NUM_BINS_DEF    = 360;
	localparam int COUNT_WIDTH_DEF = 34;

	localparam int CFG_W       = 9;
	localparam int BIN_W       = 9;
	localparam int COUNT_OUT_W = 34;
	localparam int EST_W       = 32;
	localparam int DOT_W       = 34;
	localparam int COS_W       = 32;
	localparam int S_TDATA_W   = 112;
	localparam int S_TUSER_W   = 4;
	localparam int M_TDATA_W   = 144;
	localparam int M_TUSER_W   = 2;

	localparam logic [CFG_W-1:0] CFG_RESET = 9'd360;

	localparam longint unsigned ONE_Q     = 64'd1073741824;
	localparam longint unsigned PI_Q      = 64'd3373259426;
	localparam longint unsigned HALF_PI_Q = 64'd1686629713;
	localparam longint unsigned EDGE_STEP_Q =
		(64'd436332313 * 64'd1073741824 + 64'd50000000000) / 64'd100000000000;

	typedef enum logic [1:0] {
		OP_ACCUM = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [1:0] SEL_DD = 2'd0;
	localparam logic [1:0] SEL_DR = 2'd1;
	localparam logic [1:0] SEL_RR = 2'd2;

	typedef enum logic [1:0] {
		RD_DD  = 2'd0,
		RD_DR  = 2'd1,
		RD_RR  = 2'd2,
		RD_ACC = 2'd3
	} rd_src_t;

	typedef enum logic [3:0] {
		ST_CLR_INIT,
		ST_IDLE,
		ST_DOT,
		ST_SRCH_ADDR,
		ST_SRCH_CMP,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_RD_DD,
		ST_RD_DR,
		ST_RD_RR,
		ST_RD_CAP,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_CLR,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic    take;
		logic    clr_write;
		logic    dot_step;
		logic    srch_cmp;
		logic    rd_en;
		rd_src_t rd_src;
		logic    acc_write;
		logic    cap_dd;
		logic    cap_dr;
		logic    cap_rr;
		logic    div_start;
		logic    emit;
	} cmd_t;

	typedef struct packed {
		logic s_fire;
		op_t  op;
		logic clr_last;
		logic dot_last;
		logic srch_done;
		logic acc_hit;
		logic rb_ok;
		logic div_done;
		logic out_free;
	} sts_t;

	// long division for the elaboration-time edge table
	function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int k = 63; k >= 0; k--) begin
			r = {r[62:0], n[k]};
			if (r >= d) begin
				r    = r - d;
				q[k] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic longint signed cos_taylor(longint unsigned r);
		longint unsigned x2;
		longint unsigned term;
		longint signed   sum;
		x2   = (r * r) >> 30;
		term = ONE_Q;
		sum  = longint'(ONE_Q);
		for (int n = 1; n <= 9; n++) begin
			term = udiv((term * x2) >> 30, longint'((2 * n - 1) * (2 * n)));
			if (n % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		return sum;
	endfunction

	function automatic logic signed [COS_W-1:0] edge_cos(int unsigned i);
		longint unsigned a;
		longint signed   c;
		a = longint'(i) * EDGE_STEP_Q;
		if (a <= HALF_PI_Q)
			c = cos_taylor(a);
		else if (a >= PI_Q)
			c = -longint'(ONE_Q);
		else
			c = -cos_taylor(PI_Q - a);
		return COS_W'(c);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/angular_pair_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// angular_pair_histogram_unit
// Two-point angular correlation histogram with DD, DR and RR counts per
// quarter-degree bin and a Q16.16 (DD-2DR+RR)/RR read-out.
// ----------------------------------------------------------------------------
// One transaction is taken at a time and yields one result transaction; the
// next input is taken while a result still waits on the master side, and a
// result not yet taken holds the following item in its result cycle. An
// accumulate passes through the accept state, the dot-product states (one
// shared 16x16 multiplier), an address and a compare state per step of the
// binary search over the registered cosine edge ROM (8 or 9 steps with 360
// bins in use, at most ceil(log2(bins_in_use+1))), a state that sees the
// search end, a count read and write when the bin is counted, and the result
// state. A read passes through the accept state, the DD, DR and RR reads,
// a capture and a divider start state, the divider wait and the result
// state, or goes from the DD read to the result for a bin number of
// NUM_BINS or more. A clear sweeps the count store one entry per cycle.
// After reset the same sweep runs with s_axis_tready low; configuration
// writes are taken at any time.
`default_nettype none

module angular_pair_histogram_unit #(
	parameter int NUM_BINS    = aph_pkg::NUM_BINS_DEF,
	parameter int COUNT_WIDTH = aph_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z, read_bin
	input  wire logic [aph_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// op, hist_sel
	input  wire logic [aph_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// bin_number, dd_count, dr_count, rr_count, estimate
	output logic      [aph_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// was_counted, estimate_valid
	output logic      [aph_pkg::M_TUSER_W-1:0] m_axis_tuser,
	input  wire logic                          cfg_we,
	input  wire logic [aph_pkg::CFG_W-1:0]     cfg_wdata
);

	aph_pkg::cmd_t cmd;
	aph_pkg::sts_t sts;
	logic          s_fire;

	assign s_axis_tready = cmd.take;
	assign s_fire        = s_axis_tvalid && cmd.take;

	aph_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	aph_dp #(
		.NUM_BINS   (NUM_BINS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_fire   (s_fire),
		.s_tdata  (s_axis_tdata),
		.s_tuser  (s_axis_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

// ===== rtl/core/aph_div.sv =====
// ----------------------------------------------------------------------------
// aph_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aph_div #(
	parameter int DVD_W = 51,
	parameter int DVS_W = 34
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic      [DVD_W-1:0] quotient,
	output logic                  done
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   sh;
	logic [DVS_W+1:0] diff;

	assign sh   = {rem_q, quo_q[DVD_W-1]};
	assign diff = {1'b0, sh} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DVS_W+1]) begin
				rem_q <= diff[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= sh[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = !busy_q;

endmodule

`default_nettype wire

// ===== rtl/core/aph_ctrl.sv =====
// ----------------------------------------------------------------------------
// aph_ctrl
// Controller state machine: sequences clear sweeps, dot product, edge
// search, bin update, bin read-out with division, and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module aph_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire aph_pkg::sts_t sts,
	output aph_pkg::cmd_t      cmd
);

	aph_pkg::state_t state_q;
	aph_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= aph_pkg::ST_CLR_INIT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			aph_pkg::ST_CLR_INIT: begin
				if (sts.clr_last)
					state_d = aph_pkg::ST_IDLE;
			end
			aph_pkg::ST_IDLE: begin
				if (sts.s_fire) begin
					case (sts.op)
						aph_pkg::OP_ACCUM: state_d = aph_pkg::ST_DOT;
						aph_pkg::OP_READ:  state_d = aph_pkg::ST_RD_DD;
						aph_pkg::OP_CLEAR: state_d = aph_pkg::ST_CLR;
						default:           state_d = aph_pkg::ST_RESULT;
					endcase
				end
			end
			aph_pkg::ST_DOT: begin
				if (sts.dot_last)
					state_d = aph_pkg::ST_SRCH_ADDR;
			end
			aph_pkg::ST_SRCH_ADDR: begin
				if (!sts.srch_done)
					state_d = aph_pkg::ST_SRCH_CMP;
				else if (sts.acc_hit)
					state_d = aph_pkg::ST_ACC_RD;
				else
					state_d = aph_pkg::ST_RESULT;
			end
			aph_pkg::ST_SRCH_CMP:  state_d = aph_pkg::ST_SRCH_ADDR;
			aph_pkg::ST_ACC_RD:    state_d = aph_pkg::ST_ACC_WR;
			aph_pkg::ST_ACC_WR:    state_d = aph_pkg::ST_RESULT;
			aph_pkg::ST_RD_DD: begin
				if (sts.rb_ok)
					state_d = aph_pkg::ST_RD_DR;
				else
					state_d = aph_pkg::ST_RESULT;
			end
			aph_pkg::ST_RD_DR:     state_d = aph_pkg::ST_RD_RR;
			aph_pkg::ST_RD_RR:     state_d = aph_pkg::ST_RD_CAP;
			aph_pkg::ST_RD_CAP:    state_d = aph_pkg::ST_DIV_START;
			aph_pkg::ST_DIV_START: state_d = aph_pkg::ST_DIV_WAIT;
			aph_pkg::ST_DIV_WAIT: begin
				if (sts.div_done)
					state_d = aph_pkg::ST_RESULT;
			end
			aph_pkg::ST_CLR: begin
				if (sts.clr_last)
					state_d = aph_pkg::ST_RESULT;
			end
			aph_pkg::ST_RESULT: begin
				if (sts.out_free)
					state_d = aph_pkg::ST_IDLE;
			end
			default: state_d = aph_pkg::ST_CLR_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_src = aph_pkg::RD_DD;
		case (state_q)
			aph_pkg::ST_CLR_INIT: cmd.clr_write = 1'b1;
			aph_pkg::ST_IDLE:     cmd.take = 1'b1;
			aph_pkg::ST_DOT:      cmd.dot_step = 1'b1;
			aph_pkg::ST_SRCH_CMP: cmd.srch_cmp = 1'b1;
			aph_pkg::ST_ACC_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = aph_pkg::RD_ACC;
			end
			aph_pkg::ST_ACC_WR: cmd.acc_write = 1'b1;
			aph_pkg::ST_RD_DD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = aph_pkg::RD_DD;
			end
			aph_pkg::ST_RD_DR: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = aph_pkg::RD_DR;
				cmd.cap_dd = 1'b1;
			end
			aph_pkg::ST_RD_RR: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = aph_pkg::RD_RR;
				cmd.cap_dr = 1'b1;
			end
			aph_pkg::ST_RD_CAP:    cmd.cap_rr = 1'b1;
			aph_pkg::ST_DIV_START: cmd.div_start = 1'b1;
			aph_pkg::ST_CLR:       cmd.clr_write = 1'b1;
			aph_pkg::ST_RESULT:    cmd.emit = sts.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/aph_dp.sv =====
// ----------------------------------------------------------------------------
// aph_dp
// Datapath: item registers, dot product, cosine edge ROM and search bounds,
// count store, bin read-out with estimate divider, and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aph_dp #(
	parameter int NUM_BINS    = aph_pkg::NUM_BINS_DEF,
	parameter int COUNT_WIDTH = aph_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire aph_pkg::cmd_t                 cmd,
	output aph_pkg::sts_t                      sts,
	input  wire logic                          s_fire,
	input  wire logic [aph_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic [aph_pkg::S_TUSER_W-1:0] s_tuser,
	input  wire logic                          cfg_we,
	input  wire logic [aph_pkg::CFG_W-1:0]     cfg_wdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [aph_pkg::M_TDATA_W-1:0] m_tdata,
	output logic      [aph_pkg::M_TUSER_W-1:0] m_tuser
);

	localparam int IW    = $clog2(NUM_BINS + 1);
	localparam int DEPTH = 3 * NUM_BINS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = COUNT_WIDTH;
	localparam int NUM_W = CW + 3;
	localparam int DVD_W = CW + 1 + 16;
	localparam int DOT_W = aph_pkg::DOT_W;
	localparam int COS_W = aph_pkg::COS_W;
	localparam int EST_W = aph_pkg::EST_W;
	localparam int COW   = aph_pkg::COUNT_OUT_W;
	localparam int BIN_W = aph_pkg::BIN_W;

	typedef logic signed [COS_W-1:0] cos_tab_t [NUM_BINS+1];

	function automatic cos_tab_t build_tab();
		cos_tab_t t;
		for (int i = 0; i <= NUM_BINS; i++)
			t[i] = aph_pkg::edge_cos(i);
		return t;
	endfunction

	localparam cos_tab_t EDGE_TAB = build_tab();

	// configuration and control registers
	logic [aph_pkg::CFG_W-1:0] bins_q;
	logic [AW-1:0]             clr_ptr_q;
	logic [1:0]                dot_cnt_q;
	logic                      m_tvalid_q;

	// item registers
	aph_pkg::op_t             op_q;
	logic [1:0]               sel_q;
	logic signed [15:0]       va_q [3];
	logic signed [15:0]       vb_q [3];
	logic [BIN_W-1:0]         rb_q;
	logic [IW-1:0]            lim_q;
	logic [IW-1:0]            lo_q;
	logic [IW-1:0]            hi_q;
	logic signed [31:0]       prod_q;
	logic signed [DOT_W-1:0]  dot_q;
	logic signed [COS_W-1:0]  rom_q;
	logic [CW-1:0]            mem [DEPTH];
	logic [CW-1:0]            mem_q;
	logic [CW-1:0]            dd_q;
	logic [CW-1:0]            dr_q;
	logic [CW-1:0]            rr_q;
	logic                     neg_q;
	logic                     nz_q;
	logic                     rr_zero_q;
	logic [BIN_W-1:0]         o_bin_q;
	logic                     o_cnt_q;
	logic [COW-1:0]           o_dd_q;
	logic [COW-1:0]           o_dr_q;
	logic [COW-1:0]           o_rr_q;
	logic [EST_W-1:0]         o_est_q;
	logic                     o_ev_q;

	logic [IW-1:0]            lim_d;
	logic [IW:0]              mid_w;
	logic [IW-1:0]            mid;
	logic [AW-1:0]            base;
	logic [AW-1:0]            rd_addr;
	logic [AW-1:0]            acc_addr;
	logic [AW-1:0]            rb_addr;
	logic [CW-1:0]            inc;
	logic signed [NUM_W-1:0]  num;
	logic [NUM_W-1:0]         mag_full;
	logic [DVD_W-1:0]         dividend;
	logic [DVD_W-1:0]         quo;
	logic                     div_done;
	logic                     acc_hit;
	logic                     rb_ok;
	logic [EST_W-1:0]         est;

	localparam logic [EST_W-1:0] EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
	localparam logic [EST_W-1:0] EST_MIN = {1'b1, {(EST_W-1){1'b0}}};

	always_comb begin
		if (int'(cfg_wdata) > NUM_BINS)
			lim_d = IW'(NUM_BINS);
		else
			lim_d = IW'(bins_q);
		if (int'(bins_q) > NUM_BINS)
			lim_d = IW'(NUM_BINS);
		else
			lim_d = IW'(bins_q);
	end

	assign mid_w = ({1'b0, lo_q} + {1'b0, hi_q} + 1'b1) >> 1;
	assign mid   = mid_w[IW-1:0];

	always_comb begin
		case (sel_q)
			aph_pkg::SEL_DR: base = AW'(NUM_BINS);
			aph_pkg::SEL_RR: base = AW'(2 * NUM_BINS);
			default:         base = '0;
		endcase
	end

	assign acc_addr = base + AW'(lo_q);
	assign rb_addr  = AW'(rb_q);
	assign acc_hit  = (lo_q < lim_q) && (sel_q <= aph_pkg::SEL_RR);
	assign rb_ok    = int'(rb_q) < NUM_BINS;

	always_comb begin
		case (cmd.rd_src)
			aph_pkg::RD_DR:  rd_addr = rb_addr + AW'(NUM_BINS);
			aph_pkg::RD_RR:  rd_addr = rb_addr + AW'(2 * NUM_BINS);
			aph_pkg::RD_ACC: rd_addr = acc_addr;
			default:         rd_addr = rb_addr;
		endcase
	end

	assign inc = (mem_q == {CW{1'b1}}) ? mem_q : mem_q + 1'b1;

	assign num = $signed({3'b000, dd_q}) - $signed({2'b00, dr_q, 1'b0})
		+ $signed({3'b000, rr_q});
	assign mag_full = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign dividend = {mag_full[CW:0], 16'h0000};

	aph_div #(
		.DVD_W(DVD_W),
		.DVS_W(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dividend),
		.divisor (rr_q),
		.quotient(quo),
		.done    (div_done)
	);

	always_comb begin
		if (rr_zero_q) begin
			if (!nz_q)
				est = '0;
			else if (neg_q)
				est = EST_MIN;
			else
				est = EST_MAX;
		end else if (neg_q) begin
			if (quo > DVD_W'(64'd2147483648))
				est = EST_MIN;
			else
				est = -EST_W'(quo);
		end else begin
			if (quo > DVD_W'(64'd2147483647))
				est = EST_MAX;
			else
				est = EST_W'(quo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q     <= aph_pkg::CFG_RESET;
			clr_ptr_q  <= '0;
			dot_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we)
				bins_q <= cfg_wdata;
			if (cmd.clr_write) begin
				if (clr_ptr_q == AW'(DEPTH - 1))
					clr_ptr_q <= '0;
				else
					clr_ptr_q <= clr_ptr_q + 1'b1;
			end
			if (s_fire)
				dot_cnt_q <= '0;
			else if (cmd.dot_step)
				dot_cnt_q <= dot_cnt_q + 1'b1;
			if (cmd.emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_q     <= aph_pkg::op_t'(s_tuser[1:0]);
			sel_q    <= s_tuser[3:2];
			va_q[0]  <= s_tdata[15:0];
			va_q[1]  <= s_tdata[31:16];
			va_q[2]  <= s_tdata[47:32];
			vb_q[0]  <= s_tdata[63:48];
			vb_q[1]  <= s_tdata[79:64];
			vb_q[2]  <= s_tdata[95:80];
			rb_q     <= s_tdata[104:96];
			lim_q    <= lim_d;
			lo_q     <= '0;
			hi_q     <= lim_d;
			dot_q    <= '0;
		end else begin
			if (cmd.dot_step) begin
				if (dot_cnt_q != 2'd3)
					prod_q <= va_q[dot_cnt_q] * vb_q[dot_cnt_q];
				if (dot_cnt_q != 2'd0)
					dot_q <= dot_q + DOT_W'(prod_q);
			end
			if (cmd.srch_cmp) begin
				if (dot_q <= DOT_W'(rom_q))
					lo_q <= mid;
				else
					hi_q <= mid - 1'b1;
			end
		end
		rom_q <= EDGE_TAB[mid];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_write)
			mem[clr_ptr_q] <= '0;
		else if (cmd.acc_write)
			mem[acc_addr] <= inc;
		if (cmd.rd_en)
			mem_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_dd)
			dd_q <= mem_q;
		if (cmd.cap_dr)
			dr_q <= mem_q;
		if (cmd.cap_rr)
			rr_q <= mem_q;
		if (cmd.div_start) begin
			neg_q     <= num[NUM_W-1];
			nz_q      <= num != '0;
			rr_zero_q <= rr_q == '0;
		end
		if (cmd.emit) begin
			o_bin_q <= '0;
			o_cnt_q <= 1'b0;
			o_dd_q  <= '0;
			o_dr_q  <= '0;
			o_rr_q  <= '0;
			o_est_q <= '0;
			o_ev_q  <= 1'b0;
			case (op_q)
				aph_pkg::OP_ACCUM: begin
					if (lo_q < lim_q) begin
						o_bin_q <= BIN_W'(lo_q);
						o_cnt_q <= sel_q <= aph_pkg::SEL_RR;
					end
				end
				aph_pkg::OP_READ: begin
					o_bin_q <= rb_q;
					if (rb_ok) begin
						o_dd_q  <= COW'(dd_q);
						o_dr_q  <= COW'(dr_q);
						o_rr_q  <= COW'(rr_q);
						o_est_q <= est;
						o_ev_q  <= !rr_zero_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign sts.s_fire    = s_fire;
	assign sts.op        = aph_pkg::op_t'(s_tuser[1:0]);
	assign sts.clr_last  = clr_ptr_q == AW'(DEPTH - 1);
	assign sts.dot_last  = dot_cnt_q == 2'd3;
	assign sts.srch_done = lo_q == hi_q;
	assign sts.acc_hit   = acc_hit;
	assign sts.rb_ok     = rb_ok;
	assign sts.div_done  = div_done;
	assign sts.out_free  = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, o_est_q, o_rr_q, o_dr_q, o_dd_q, o_bin_q};
	assign m_tuser  = {o_ev_q, o_cnt_q};

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.srch_cmp |-> lo_q < hi_q && hi_q <= lim_q)
		else $error("search bounds out of order");

	a_clr_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.clr_write) && !cmd.clr_write |-> clr_ptr_q == '0)
		else $error("clear pointer not back at zero after sweep");

	a_est_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && op_q == aph_pkg::OP_READ && rb_ok |=> o_ev_q == (rr_q != '0))
		else $error("estimate valid flag disagrees with RR count");

endmodule

`default_nettype wire

// ===== sim/angular_pair_histogram_unit_tb.sv =====
// ----------------------------------------------------------------------------
// angular_pair_histogram_unit_tb
// Drives accumulate, read, clear and idle transactions into the angular pair
// histogram unit under bursty input and a stalling output. An in-bench model
// keeps the counts and the bin setting and checks each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

class aph_scoreboard;
	typedef struct {
		logic [8:0]         bin_number;
		logic               was_counted;
		logic [33:0]        dd, dr, rr;
		logic signed [31:0] estimate;
		logic               estimate_valid;
	} result_t;

	localparam int NB = 360;
	longint unsigned counts[3*NB];
	longint signed   edge_cosine[1:NB];
	int unsigned     bins_cfg;
	result_t         pending[$];
	int              errors;

	function new();
		longint unsigned step, a;
		step = (64'd436332313 * 64'd1073741824 + 64'd50000000000) / 64'd100000000000;
		for (int i = 1; i <= NB; i++) begin
			a = longint'(i) * step;
			if (a <= 64'd1686629713)
				edge_cosine[i] = taylor_cos(a);
			else if (a >= 64'd3373259426)
				edge_cosine[i] = -64'sd1073741824;
			else
				edge_cosine[i] = -taylor_cos(64'd3373259426 - a);
		end
		foreach (counts[k]) counts[k] = 0;
		bins_cfg = 360;
		errors = 0;
	endfunction

	function longint signed taylor_cos(longint unsigned r);
		longint unsigned x2, term;
		longint signed   acc;
		x2 = (r * r) >> 30;
		term = 64'd1073741824;
		acc = 64'sd1073741824;
		for (int n = 1; n <= 9; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
			acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
		end
		return acc;
	endfunction

	function void ratio_q16(longint unsigned dd, dr, rr, output logic signed [31:0] e,
			output logic v);
		longint signed   num;
		longint unsigned mag, ip, m;
		num = longint'(dd) - 2 * longint'(dr) + longint'(rr);
		mag = (num < 0) ? longint'(-num) : longint'(num);
		if (rr == 0) begin
			v = 0;
			e = (num > 0) ? 32'sh7fffffff : (num < 0) ? 32'sh80000000 : 32'sd0;
			return;
		end
		v = 1;
		ip = mag / rr;
		m = (ip >= 65536) ? 64'hFF_FFFF_FFFF : ((ip << 16) | (((mag % rr) << 16) / rr));
		if (num < 0)
			e = (m > 64'd2147483648) ? 32'sh80000000 : 32'(-longint'(m));
		else
			e = (m > 64'd2147483647) ? 32'sh7fffffff : 32'(m);
	endfunction

	function void note(aph_pkg::op_t op, logic [1:0] sel, logic [111:0] d);
		result_t         r;
		longint signed   dot;
		int unsigned     lim, b;
		r = '{default: '0};
		case (op)
			aph_pkg::OP_ACCUM: begin
				dot = longint'($signed(d[15:0])) * longint'($signed(d[63:48]))
					+ longint'($signed(d[31:16])) * longint'($signed(d[79:64]))
					+ longint'($signed(d[47:32])) * longint'($signed(d[95:80]));
				lim = (bins_cfg > NB) ? NB : bins_cfg;
				b = 0;
				for (int i = 1; i <= lim; i++)
					if (dot <= edge_cosine[i]) b++;
				if (b < lim) begin
					r.bin_number = b;
					if (sel != 2'd3) begin
						if (counts[sel*NB+b] < 64'h3_FFFF_FFFF) counts[sel*NB+b]++;
						r.was_counted = 1;
					end
				end
			end
			aph_pkg::OP_READ: begin
				r.bin_number = d[104:96];
				if (d[104:96] < NB) begin
					r.dd = counts[d[104:96]];
					r.dr = counts[NB + d[104:96]];
					r.rr = counts[2*NB + d[104:96]];
					ratio_q16(r.dd, r.dr, r.rr, r.estimate, r.estimate_valid);
				end
			end
			aph_pkg::OP_CLEAR: foreach (counts[k]) counts[k] = 0;
			default: ;
		endcase
		pending = {pending, r};
	endfunction

	function void check(logic [143:0] d, logic [1:0] u);
		result_t x;
		if (pending.size() == 0) begin
			$error("result with no expectation: tdata %h tuser %b", d, u);
			errors++;
			return;
		end
		x = pending.pop_front();
		cmp("bin_number", x.bin_number, d[8:0]);
		cmp("dd_count", x.dd, d[42:9]);
		cmp("dr_count", x.dr, d[76:43]);
		cmp("rr_count", x.rr, d[110:77]);
		cmp("estimate", 64'(unsigned'(x.estimate)), d[142:111]);
		cmp("was_counted", x.was_counted, u[0]);
		cmp("estimate_valid", x.estimate_valid, u[1]);
	endfunction

	function void cmp(string name, longint unsigned want, longint unsigned got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction
endclass

module angular_pair_histogram_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                          clk = 0;
	logic                          arst_n = 0;
	logic                          s_axis_tvalid = 0;
	logic                          s_axis_tready;
	logic [aph_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [aph_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 0;
	logic [aph_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic [aph_pkg::M_TUSER_W-1:0] m_axis_tuser;
	logic                          cfg_we = 0;
	logic [aph_pkg::CFG_W-1:0]     cfg_wdata = '0;

	aph_scoreboard histo = new();
	int burst_left = 0;
	int cycle_count = 0;

	angular_pair_histogram_unit DUT (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .cfg_we, .cfg_wdata
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		case ((cycle_count / 300) % 3)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 1) == 1);
			default: m_axis_tready <= ($urandom_range(0, 7) == 0);
		endcase
		if (arst_n && m_axis_tvalid && m_axis_tready)
			histo.check(m_axis_tdata, m_axis_tuser);
	end

	task automatic send(aph_pkg::op_t op, logic [1:0] sel, logic [111:0] d);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tuser <= {sel, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		histo.note(op, sel, d);
	endtask

	function automatic logic [111:0] pack_pair(shortint fx, fy, fz, sx, sy, sz, int rb);
		return {7'($urandom), 9'(rb), sz, sy, sx, fz, fy, fx};
	endfunction

	function automatic logic [111:0] angled_pair(real span);
		real a, t, b;
		a = $urandom_range(0, 62831) / 10000.0;
		b = $urandom_range(0, 31415) / 10000.0;
		t = span * $urandom_range(0, 10000) / 10000.0;
		return pack_pair(shortint'($rtoi(32767.0 * $cos(a) * $sin(b))),
			shortint'($rtoi(32767.0 * $sin(a) * $sin(b))),
			shortint'($rtoi(32767.0 * $cos(b))),
			shortint'($rtoi(32767.0 * $cos(a + t) * $sin(b))),
			shortint'($rtoi(32767.0 * $sin(a + t) * $sin(b))),
			shortint'($rtoi(32767.0 * $cos(b))), $urandom_range(0, 511));
	endfunction

	task automatic set_bins(logic [8:0] v);
		s_axis_tvalid <= 1'b0;
		while (histo.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		histo.bins_cfg = v;
	endtask

	task automatic random_phase(int n);
		int unsigned lim;
		int          r;
		lim = (histo.bins_cfg > 360) ? 360 : histo.bins_cfg;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				send(aph_pkg::OP_ACCUM, 2'($urandom_range(0, 3)),
					angled_pair(($urandom_range(0, 1) ? lim : 720) * 0.00436332313 * 1.1));
			else if (r < 70)
				send(aph_pkg::OP_ACCUM, 2'($urandom),
					112'({$urandom, $urandom, $urandom, $urandom}));
			else if (r < 94)
				send(aph_pkg::OP_READ, 2'($urandom), pack_pair(0, 0, 0, 0, 0, 0,
					$urandom_range(0, 9) ? $urandom_range(0, lim > 0 ? lim - 1 : 0)
						: $urandom_range(0, 511)));
			else if (r < 97)
				send(aph_pkg::OP_NONE, 2'($urandom),
					112'({$urandom, $urandom, $urandom, $urandom}));
			else
				send(aph_pkg::OP_CLEAR, 2'($urandom),
					112'({$urandom, $urandom, $urandom, $urandom}));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		set_bins(9'd360);
		send(aph_pkg::OP_ACCUM, aph_pkg::SEL_DD,
			pack_pair(-32768, -32768, -32768, -32768, -32768, -32768, 0));
		send(aph_pkg::OP_ACCUM, aph_pkg::SEL_DR,
			pack_pair(32767, 32767, 32767, -32768, -32768, -32768, 0));
		send(aph_pkg::OP_ACCUM, aph_pkg::SEL_RR, pack_pair(0, 0, 0, 0, 0, 0, 0));
		send(aph_pkg::OP_ACCUM, aph_pkg::SEL_RR, pack_pair(32767, 0, 0, 32767, 0, 0, 0));
		send(aph_pkg::OP_ACCUM, aph_pkg::SEL_RR, pack_pair(32767, 0, 0, 32767, 0, 0, 0));
		send(aph_pkg::OP_ACCUM, aph_pkg::SEL_DR, pack_pair(32767, 0, 0, 32767, 0, 0, 0));
		send(aph_pkg::OP_ACCUM, 2'd3, pack_pair(32767, 0, 0, 32767, 0, 0, 0));
		send(aph_pkg::OP_ACCUM, aph_pkg::SEL_DD, pack_pair(32767, 0, 0, 32700, 2000, 0, 0));
		send(aph_pkg::OP_ACCUM, aph_pkg::SEL_DD, pack_pair(0, 32767, 0, 0, 32767, 0, 0));
		send(aph_pkg::OP_READ, aph_pkg::SEL_DD, pack_pair(0, 0, 0, 0, 0, 0, 0));
		send(aph_pkg::OP_READ, aph_pkg::SEL_DD, pack_pair(0, 0, 0, 0, 0, 0, 1));
		send(aph_pkg::OP_READ, aph_pkg::SEL_DD, pack_pair(0, 0, 0, 0, 0, 0, 359));
		send(aph_pkg::OP_READ, aph_pkg::SEL_DD, pack_pair(0, 0, 0, 0, 0, 0, 360));
		send(aph_pkg::OP_READ, aph_pkg::SEL_DD, pack_pair(-1, -1, -1, -1, -1, -1, 511));
		send(aph_pkg::OP_NONE, 2'd3, '1);
		send(aph_pkg::OP_CLEAR, aph_pkg::SEL_DD, '0);
		send(aph_pkg::OP_READ, aph_pkg::SEL_DD, pack_pair(0, 0, 0, 0, 0, 0, 0));
		random_phase(200);
		set_bins(9'd1);
		random_phase(100);
		set_bins(9'd0);
		random_phase(60);
		set_bins(9'd45);
		random_phase(180);
		set_bins(9'd511);
		random_phase(120);
		set_bins(9'd180);
		random_phase(240);
		s_axis_tvalid <= 1'b0;
		while (histo.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (histo.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/aph_pkg.sv
rtl/core/aph_div.sv
rtl/core/aph_ctrl.sv
rtl/core/aph_dp.sv
rtl/core/angular_pair_histogram_unit.sv
sim/angular_pair_histogram_unit_tb.sv
